// ===== rtl/core/abss_pkg.sv =====
// ----------------------------------------------------------------------------
// abss_pkg
// Types, constants and the microcode table of the band size smoother.
// ----------------------------------------------------------------------------
package abss_pkg;

    localparam int LEVEL_W  = 16;
    localparam int SIZE_W   = 16;
    localparam int WEIGHT_W = 17;
    localparam int DEN_W    = WEIGHT_W + 1;
    localparam int PROD_W   = SIZE_W + WEIGHT_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int PC_W     = 4;
    localparam int CNT_W    = 5;

    localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [ACC_W-1:0]    HALF_Q16  = 34'h8000;
    localparam logic [CNT_W-1:0]    DIV_STEPS = 5'd16;

    typedef enum logic [1:0] {
        CFG_MIN_SIZE      = 2'd0,
        CFG_MAX_SIZE      = 2'd1,
        CFG_ATTACK_WEIGHT = 2'd2,
        CFG_GAIN_WEIGHT   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   min_size;
        logic [SIZE_W-1:0]   max_size;
        logic [WEIGHT_W-1:0] attack_weight;
        logic [WEIGHT_W-1:0] gain_weight;
    } cfg_t;

    typedef enum logic [2:0] {
        MA_DELTA = 3'd0,
        MA_LEVEL = 3'd1,
        MA_DSIZE = 3'd2,
        MA_LSIZE = 3'd3,
        MA_AAVG  = 3'd4,
        MA_GAVG  = 3'd5
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        MB_RANGE  = 3'd0,
        MB_AW     = 3'd1,
        MB_AW_INV = 3'd2,
        MB_GW     = 3'd3,
        MB_GW_INV = 3'd4
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        AD_ZERO     = 2'd0,
        AD_HALF     = 2'd1,
        AD_DEN_HALF = 2'd2
    } add_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [2:0] {
        DST_NONE  = 3'd0,
        DST_DSIZE = 3'd1,
        DST_LSIZE = 3'd2,
        DST_AAVG  = 3'd3,
        DST_GAVG  = 3'd4
    } dest_t;

    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_DIV_INIT = 2'd1,
        OP_DIV_STEP = 2'd2,
        OP_OUT      = 2'd3
    } seq_op_t;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_DIV_MORE = 2'd1,
        COND_OUT_BUSY = 2'd2
    } cond_t;

    typedef struct packed {
        mul_a_sel_t       mul_a;
        mul_b_sel_t       mul_b;
        add_sel_t         addend;
        acc_op_t          acc_op;
        dest_t            dest;
        seq_op_t          op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } ctrl_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        mul_a: MA_DELTA, mul_b: MB_RANGE, addend: AD_ZERO, acc_op: ACC_HOLD,
        dest: DST_NONE, op: OP_NONE, cond: COND_NONE, target: '0, last: 1'b0
    };

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = CTRL_NOP;
        unique case (pc)
            4'd0: begin
                c.mul_a = MA_DELTA; c.mul_b = MB_RANGE;
                c.addend = AD_HALF; c.acc_op = ACC_LOAD;
            end
            4'd1: begin
                c.mul_a = MA_LEVEL; c.mul_b = MB_RANGE;
                c.addend = AD_HALF; c.acc_op = ACC_LOAD; c.dest = DST_DSIZE;
            end
            4'd2: begin
                c.mul_a = MA_DSIZE; c.mul_b = MB_AW;
                c.addend = AD_HALF; c.acc_op = ACC_LOAD; c.dest = DST_LSIZE;
            end
            4'd3: begin
                c.mul_a = MA_AAVG; c.mul_b = MB_AW_INV; c.acc_op = ACC_ADD;
            end
            4'd4: begin
                c.mul_a = MA_LSIZE; c.mul_b = MB_GW;
                c.addend = AD_HALF; c.acc_op = ACC_LOAD; c.dest = DST_AAVG;
            end
            4'd5: begin
                c.mul_a = MA_GAVG; c.mul_b = MB_GW_INV; c.acc_op = ACC_ADD;
            end
            4'd6: begin
                c.dest = DST_GAVG;
            end
            4'd7: begin
                c.mul_a = MA_GAVG; c.mul_b = MB_GW;
                c.addend = AD_DEN_HALF; c.acc_op = ACC_LOAD;
            end
            4'd8: begin
                c.mul_a = MA_AAVG; c.mul_b = MB_AW; c.acc_op = ACC_ADD;
            end
            4'd9: begin
                c.op = OP_DIV_INIT;
            end
            4'd10: begin
                c.op = OP_DIV_STEP; c.cond = COND_DIV_MORE; c.target = 4'd10;
            end
            4'd11: begin
                c.op = OP_OUT; c.cond = COND_OUT_BUSY; c.target = 4'd11;
                c.last = 1'b1;
            end
            default: begin
                c.last = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/abss_seq.sv =====
// ----------------------------------------------------------------------------
// abss_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module abss_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  abss_pkg::status_t status,
    output abss_pkg::ctrl_t   ctrl,
    output logic              busy
);
    import abss_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            run_reg, run_next;
    ctrl_t           word;
    logic            jump;

    assign word = ucode(pc_reg);
    assign ctrl = run_reg ? word : CTRL_NOP;
    assign busy = run_reg;

    always_comb begin
        jump     = 1'b0;
        pc_next  = pc_reg;
        run_next = run_reg;
        if (!run_reg) begin
            if (start) begin
                run_next = 1'b1;
                pc_next  = '0;
            end
        end else begin
            unique case (word.cond)
                COND_DIV_MORE: jump = !status.div_last;
                COND_OUT_BUSY: jump = !status.out_free;
                default:       jump = 1'b0;
            endcase
            if (jump) begin
                pc_next = word.target;
            end else if (word.last) begin
                run_next = 1'b0;
                pc_next  = '0;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= '0;
            run_reg <= 1'b0;
        end else begin
            pc_reg  <= pc_next;
            run_reg <= run_next;
        end
    end

endmodule

// ===== rtl/core/abss_datapath.sv =====
// ----------------------------------------------------------------------------
// abss_datapath
// Multiply-accumulate, state registers, restoring divider and output register.
// ----------------------------------------------------------------------------
module abss_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  abss_pkg::cfg_t                cfg,
    input  abss_pkg::ctrl_t               ctrl,
    input  logic                          start,
    input  logic [abss_pkg::LEVEL_W-1:0]  level_in,
    output abss_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [abss_pkg::SIZE_W-1:0]   out_size
);
    import abss_pkg::*;

    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  prev_reg, prev_next;
    logic [SIZE_W-1:0]   aavg_reg, aavg_next;
    logic [SIZE_W-1:0]   gavg_reg, gavg_next;
    logic [SIZE_W-1:0]   dsize_reg, dsize_next;
    logic [SIZE_W-1:0]   lsize_reg, lsize_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SIZE_W-1:0]   out_reg, out_next;
    logic                valid_reg, valid_next;

    logic [SIZE_W-1:0]   lo, hi, range;
    logic [WEIGHT_W-1:0] aw, gw, aw_inv, gw_inv;
    logic [DEN_W-1:0]    den;
    logic [LEVEL_W-1:0]  delta;
    logic [SIZE_W-1:0]   op_a;
    logic [WEIGHT_W-1:0] op_b;
    logic [PROD_W-1:0]   prod;
    logic [ACC_W-1:0]    addend;
    logic [SIZE_W-1:0]   acc_hi;
    logic [DEN_W:0]      trial;
    logic                fits;
    logic [SIZE_W-1:0]   result;
    logic                out_free;

    assign lo     = cfg.min_size;
    assign hi     = (cfg.max_size < cfg.min_size) ? cfg.min_size : cfg.max_size;
    assign range  = hi - lo;
    assign aw     = (cfg.attack_weight > ONE_Q16) ? ONE_Q16 : cfg.attack_weight;
    assign gw     = (cfg.gain_weight > ONE_Q16) ? ONE_Q16 : cfg.gain_weight;
    assign aw_inv = ONE_Q16 - aw;
    assign gw_inv = ONE_Q16 - gw;
    assign den    = {1'b0, aw} + {1'b0, gw};
    assign delta  = (level_reg >= prev_reg) ? (level_reg - prev_reg)
                                            : (prev_reg - level_reg);
    assign acc_hi = acc_reg[PROD_W-2:SIZE_W];

    always_comb begin
        unique case (ctrl.mul_a)
            MA_DELTA: op_a = delta;
            MA_LEVEL: op_a = level_reg;
            MA_DSIZE: op_a = dsize_reg;
            MA_LSIZE: op_a = lsize_reg;
            MA_AAVG:  op_a = aavg_reg;
            MA_GAVG:  op_a = gavg_reg;
            default:  op_a = '0;
        endcase
        unique case (ctrl.mul_b)
            MB_RANGE:  op_b = {1'b0, range};
            MB_AW:     op_b = aw;
            MB_AW_INV: op_b = aw_inv;
            MB_GW:     op_b = gw;
            MB_GW_INV: op_b = gw_inv;
            default:   op_b = '0;
        endcase
        unique case (ctrl.addend)
            AD_HALF:     addend = HALF_Q16;
            AD_DEN_HALF: addend = {{(ACC_W-DEN_W+1){1'b0}}, den[DEN_W-1:1]};
            default:     addend = '0;
        endcase
    end

    assign prod = {{WEIGHT_W{1'b0}}, op_a} * {{SIZE_W{1'b0}}, op_b};

    assign trial = {rem_reg, quot_reg[SIZE_W-1]};
    assign fits  = trial >= {1'b0, den};

    always_comb begin
        if (den == '0) begin
            result = lo;
        end else if (quot_reg < lo) begin
            result = lo;
        end else if (quot_reg > hi) begin
            result = hi;
        end else begin
            result = quot_reg;
        end
    end

    assign out_free = !valid_reg || out_ready;
    assign status   = '{div_last: (cnt_reg == CNT_W'(1)), out_free: out_free};

    always_comb begin
        acc_next   = acc_reg;
        dsize_next = dsize_reg;
        lsize_next = lsize_reg;
        aavg_next  = aavg_reg;
        gavg_next  = gavg_reg;
        prev_next  = prev_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        valid_next = valid_reg;

        unique case (ctrl.acc_op)
            ACC_LOAD: acc_next = {1'b0, prod} + addend;
            ACC_ADD:  acc_next = acc_reg + {1'b0, prod};
            default:  acc_next = acc_reg;
        endcase

        unique case (ctrl.dest)
            DST_DSIZE: dsize_next = lo + acc_hi;
            DST_LSIZE: lsize_next = lo + acc_hi;
            DST_AAVG:  aavg_next  = acc_hi;
            DST_GAVG: begin
                gavg_next = acc_hi;
                prev_next = level_reg;
            end
            default: ;
        endcase

        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end

        unique case (ctrl.op)
            OP_DIV_INIT: begin
                rem_next  = acc_reg[ACC_W-1:SIZE_W];
                quot_next = acc_reg[SIZE_W-1:0];
                cnt_next  = DIV_STEPS;
            end
            OP_DIV_STEP: begin
                rem_next  = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
                quot_next = {quot_reg[SIZE_W-2:0], fits};
                cnt_next  = cnt_reg - 1'b1;
            end
            OP_OUT: begin
                if (out_free) begin
                    out_next   = result;
                    valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            level_reg <= level_in;
        end
        acc_reg   <= acc_next;
        dsize_reg <= dsize_next;
        lsize_reg <= lsize_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            aavg_reg  <= '0;
            gavg_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            prev_reg  <= prev_next;
            aavg_reg  <= aavg_next;
            gavg_reg  <= gavg_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_size  = out_reg;

endmodule

// ===== rtl/core/audio_band_size_smoother.sv =====
// ----------------------------------------------------------------------------
// audio_band_size_smoother
// Maps each band level and its change into a size range, smooths both with
// exponential averages and outputs their weighted mean, clamped to the range.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_band_level carry one band level (Q0.16) per request.
//   m_valid/m_ready/m_display_size return one size (Q8.8) per request.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write min_size, max_size,
//   attack_weight and gain_weight; cfg_ready is always high. Write only
//   while no request is in flight.
//   The microcode runs 27 steps from a 12-word table on one shared
//   16x17 multiply-accumulate, 16 of them being the one-bit-per-step
//   restoring divide; the next request is taken only once the sequencer
//   is idle again.
//   s_ready is high while the sequencer is idle, also while a result still
//   waits in the output register. If the receiver stalls, the sequencer
//   holds at its output step until the register frees.
//   Reset clears the previous level, both averages and loads the register
//   defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module audio_band_size_smoother (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [abss_pkg::LEVEL_W-1:0]  s_band_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [abss_pkg::SIZE_W-1:0]   m_display_size,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  abss_pkg::cfg_index_t          cfg_index,
    input  logic [abss_pkg::WEIGHT_W-1:0] cfg_data
);
    import abss_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    ctrl_t   ctrl;
    status_t status;
    logic    busy;
    logic    start;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;
    assign start     = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_SIZE:      cfg_next.min_size      = cfg_data[SIZE_W-1:0];
                CFG_MAX_SIZE:      cfg_next.max_size      = cfg_data[SIZE_W-1:0];
                CFG_ATTACK_WEIGHT: cfg_next.attack_weight = cfg_data;
                CFG_GAIN_WEIGHT:   cfg_next.gain_weight   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_size      <= '0;
            cfg_reg.max_size      <= 16'hFFFF;
            cfg_reg.attack_weight <= 17'h08000;
            cfg_reg.gain_weight   <= 17'h08000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    abss_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .status  (status),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    abss_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .start     (start),
        .level_in  (s_band_level),
        .status    (status),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_size  (m_display_size)
    );

    // busy right after a request is taken
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("sequencer idle after accepting a request");

    // result always lies within the configured range
    a_result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_display_size >= cfg_reg.min_size) &&
                    ((m_display_size <= cfg_reg.max_size) ||
                     (m_display_size == cfg_reg.min_size)))
        else $error("display size outside configured range");

    // a new result only comes from a running sequence
    a_result_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(busy))
        else $error("result issued without a running sequence");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the band size smoother against a cycle-free model of its arithmetic:
// directed level sequences for each corner of the settings, then random
// levels under random settings, random stalls and long output back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    import abss_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_LEVELS  = 250;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [LEVEL_W-1:0]    s_band_level;
    logic                  m_valid;
    logic                  m_ready;
    logic [SIZE_W-1:0]     m_display_size;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [WEIGHT_W-1:0]   cfg_data;

    // mirrored registers and smoother state
    logic [SIZE_W-1:0]     set_min;
    logic [SIZE_W-1:0]     set_max;
    logic [WEIGHT_W-1:0]   set_attack_w;
    logic [WEIGHT_W-1:0]   set_gain_w;
    logic [LEVEL_W-1:0]    prev_level;
    logic [SIZE_W-1:0]     attack_avg;
    logic [SIZE_W-1:0]     gain_avg;

    logic [SIZE_W-1:0]     pending_sizes[$];
    int                    levels_sent;
    int                    sizes_checked;
    int                    settings_loaded;
    int                    mismatches;
    int                    rx_hold_cycles;
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    bit                    offer_open;

    audio_band_size_smoother dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_band_level   (s_band_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_display_size (m_display_size),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [SIZE_W-1:0] map_to_range(input logic [LEVEL_W-1:0] frac,
            input logic [SIZE_W-1:0] lo, input logic [SIZE_W-1:0] span);
        logic [63:0] prod;
        prod = 64'(frac) * 64'(span) + 64'd32768;
        return lo + prod[31:16];
    endfunction

    function automatic logic [SIZE_W-1:0] ema_step(input logic [SIZE_W-1:0] target,
            input logic [SIZE_W-1:0] avg, input logic [WEIGHT_W-1:0] w);
        logic [63:0] acc;
        acc = 64'(target) * 64'(w) + 64'(avg) * (64'd65536 - 64'(w)) + 64'd32768;
        return acc[31:16];
    endfunction

    function automatic logic [WEIGHT_W-1:0] limit_weight(input logic [WEIGHT_W-1:0] w);
        return (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

    // advances the smoother state by one level and returns the size it yields
    function automatic logic [SIZE_W-1:0] predict_display_size(
            input logic [LEVEL_W-1:0] level);
        logic [SIZE_W-1:0]   lo;
        logic [SIZE_W-1:0]   hi;
        logic [SIZE_W-1:0]   span;
        logic [LEVEL_W-1:0]  delta;
        logic [SIZE_W-1:0]   dsize;
        logic [SIZE_W-1:0]   lsize;
        logic [WEIGHT_W-1:0] aw;
        logic [WEIGHT_W-1:0] gw;
        logic [DEN_W-1:0]    den;
        logic [63:0]         num;
        logic [63:0]         q;
        lo    = set_min;
        hi    = (set_max < set_min) ? set_min : set_max;
        span  = hi - lo;
        aw    = limit_weight(set_attack_w);
        gw    = limit_weight(set_gain_w);
        delta = (level >= prev_level) ? level - prev_level : prev_level - level;
        dsize = map_to_range(delta, lo, span);
        lsize = map_to_range(level, lo, span);
        prev_level = level;
        attack_avg = ema_step(dsize, attack_avg, aw);
        gain_avg   = ema_step(lsize, gain_avg, gw);
        den = DEN_W'(aw) + DEN_W'(gw);
        if (den == '0) begin
            return lo;
        end
        num = 64'(gain_avg) * 64'(gw) + 64'(attack_avg) * 64'(aw) + 64'(den >> 1);
        q = num / 64'(den);
        if (q < 64'(lo)) q = 64'(lo);
        if (q > 64'(hi)) q = 64'(hi);
        return q[SIZE_W-1:0];
    endfunction

    task automatic send_level(input logic [LEVEL_W-1:0] level);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            if (offer_open) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_band_level <= level;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_sizes.push_back(predict_display_size(level));
        offer_open = 1'b1;
        levels_sent++;
    endtask

    task automatic wait_idle();
        if (offer_open) begin
            s_valid <= 1'b0;
            offer_open = 1'b0;
        end
        while (pending_sizes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [WEIGHT_W-1:0] min_v,
            input logic [WEIGHT_W-1:0] max_v, input logic [WEIGHT_W-1:0] aw_v,
            input logic [WEIGHT_W-1:0] gw_v);
        cfg_index_t          order [4] = '{CFG_MIN_SIZE, CFG_MAX_SIZE,
                                           CFG_ATTACK_WEIGHT, CFG_GAIN_WEIGHT};
        logic [WEIGHT_W-1:0] vals  [4];
        vals = '{min_v, max_v, aw_v, gw_v};
        wait_idle();
        cfg_valid <= 1'b1;
        foreach (order[i]) begin
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (order[i])
                CFG_MIN_SIZE:      set_min      = vals[i][SIZE_W-1:0];
                CFG_MAX_SIZE:      set_max      = vals[i][SIZE_W-1:0];
                CFG_ATTACK_WEIGHT: set_attack_w = vals[i];
                CFG_GAIN_WEIGHT:   set_gain_w   = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_size();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 17'h0ffff;
            default: return WEIGHT_W'($urandom());
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return WEIGHT_W'($urandom_range(65537, 131071));
            default: return WEIGHT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] next_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return prev_level + LEVEL_W'($urandom_range(0, 255));
            3:       return prev_level - LEVEL_W'($urandom_range(0, 255));
            default: return LEVEL_W'($urandom());
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_level(16'h0000);
        send_level(16'hffff);
        send_level(16'h0000);
        send_level(16'h8000);
    endtask

    // averages still low, so the clamp lifts results to min
    task automatic test_averages_below_min();
        load_settings(17'h0f000, 17'h0ffff, 17'h00400, 17'h00400);
        send_level(16'hffff);
        send_level(16'h0000);
        send_level(16'hffff);
    endtask

    task automatic test_full_weights();
        load_settings(17'h00000, 17'h0ffff, ONE_Q16, ONE_Q16);
        send_level(16'h0000);
        send_level(16'hffff);
        send_level(16'h0000);
        send_level(16'hffff);
    endtask

    task automatic test_zero_weights();
        load_settings(17'h00100, 17'h0ff00, 17'h00000, 17'h00000);
        send_level(16'h1234);
        send_level(16'hffff);
    endtask

    task automatic test_weight_above_one();
        load_settings(17'h00000, 17'h0ffff, 17'h1ffff, 17'h10001);
        send_level(16'h8000);
        send_level(16'h0000);
        send_level(16'hffff);
    endtask

    task automatic test_max_below_min();
        load_settings(17'h08000, 17'h01000, 17'h08000, 17'h08000);
        send_level(16'hffff);
        send_level(16'h0000);
    endtask

    task automatic test_min_equals_max();
        load_settings(17'h1ffff, 17'h0ffff, 17'h00000, ONE_Q16);
        send_level(16'h0000);
        send_level(16'hffff);
    endtask

    task automatic test_random_settings(input int phases);
        logic [WEIGHT_W-1:0] lo;
        logic [WEIGHT_W-1:0] hi;
        logic [WEIGHT_W-1:0] tmp;
        for (int p = 0; p < phases; p++) begin
            lo = pick_size();
            hi = pick_size();
            if (hi[SIZE_W-1:0] < lo[SIZE_W-1:0] && $urandom_range(0, 3) != 0) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            load_settings(lo, hi, pick_weight(), pick_weight());
            tx_idle_on = (p % 4 == 0) || (p % 4 == 2);
            rx_idle_on = (p % 4 == 0) || (p % 4 == 3);
            repeat (PHASE_LEVELS) send_level(next_level());
        end
    endtask

    // receiver holds off while levels keep coming, so the input stalls
    task automatic test_backpressure();
        load_settings(17'h00200, 17'h0fe00, WEIGHT_W'($urandom_range(0, 65536)),
                      WEIGHT_W'($urandom_range(0, 65536)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (PHASE_LEVELS / 2) send_level(next_level());
        rx_hold_cycles = HOLD_CYCLES;
        repeat (PHASE_LEVELS / 2) send_level(next_level());
        tx_idle_on = 1'b1;
    endtask

    initial begin : size_checker
        int gap;
        int hold;
        logic [SIZE_W-1:0] want;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            gap = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (pending_sizes.size() == 0) begin
                mismatches++;
                $display("%0t: display_size expected none, actual %0d", $time,
                         m_display_size);
            end else begin
                want = pending_sizes.pop_front();
                sizes_checked++;
                if (m_display_size !== want) begin
                    mismatches++;
                    $display("%0t: display_size expected %0d, actual %0d", $time,
                             want, m_display_size);
                end
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : run
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_band_level <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_MIN_SIZE;
        cfg_data     <= '0;
        set_min      = '0;
        set_max      = 16'hffff;
        set_attack_w = 17'h08000;
        set_gain_w   = 17'h08000;
        prev_level   = '0;
        attack_avg   = '0;
        gain_avg     = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_averages_below_min();
        test_full_weights();
        test_zero_weights();
        test_weight_above_one();
        test_max_below_min();
        test_min_equals_max();
        test_random_settings(6);
        test_backpressure();
        wait_idle();

        $display("tb: %0d levels sent, %0d sizes checked, %0d settings loaded",
                 levels_sent, sizes_checked, settings_loaded);
        $display("tb: covered default, zero, full and over-range weights, empty range,");
        $display("tb: random ranges with stalls and long output hold-off");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/abss_pkg.sv
rtl/core/abss_seq.sv
rtl/core/abss_datapath.sv
rtl/core/audio_band_size_smoother.sv
tb/sv/testbench.sv
